### design/vtpy_pkg.sv
// Shared types, constants and helper functions for vector_to_pitch_yaw.
// No dependencies; used by vtpy_isqrt, vtpy_cordic and the top level.
package vtpy_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int FRAC_BITS     = 16;

    localparam int IN_W    = 32;                  // Q16.16 vector components
    localparam int EPS_W   = 16;
    localparam int DEG_W   = 25;                  // Q9.16 output angle
    localparam int GUARD_SH = 20;                 // operands scaled by 2^20
    localparam int CW      = IN_W + GUARD_SH + 4; // CORDIC x/y width
    localparam int ACC_W   = FRAC_BITS + 10;      // angle accumulator, +-512 deg
    localparam int SQ_W    = 2 * IN_W;
    localparam int ROOT_W  = IN_W;
    localparam int ISQ_STEPS = SQ_W / 2;
    localparam int WRAP_W  = DEG_W + 2;           // signed scratch for the wrap

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

    localparam logic [63:0] PICO_DEG = 64'd1000000000000;

    localparam logic [63:0] ATAN_PICO [32] = '{
        64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
        64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
        64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
        64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427,
        64'd874264214,      64'd437132107,      64'd218566053,      64'd109283027,
        64'd54641513,       64'd27320757,       64'd13660378,       64'd6830189,
        64'd3415095,        64'd1707547,        64'd853774,         64'd426887,
        64'd213443,         64'd106722,         64'd53361,          64'd26680
    };

    localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90 * 65536);
    localparam logic [DEG_W-1:0] DEG_270 = DEG_W'(270 * 65536);
    localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360 * 65536);

    // rounding / widening shifts from the accumulator to Q9.16
    localparam int DN_SH  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int RND_SH = (FRAC_BITS > 16) ? FRAC_BITS - 17 : 0;
    localparam int UP_SH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    // sideband carried next to the datapath ahead of the CORDIC
    typedef struct packed {
        logic                   valid;
        logic                   degen;
        logic                   zpos;
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
    } side_t;

    // sideband through the CORDIC
    typedef struct packed {
        logic valid;
        logic degen;
        logic zpos;
    } tag_t;

    // one CORDIC lane
    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ACC_W-1:0] acc;
    } lane_t;

    // atan(2^-i) in accumulator units, rounded half up; elaboration time only
    function automatic logic [ACC_W-1:0] stage_angle(input int unsigned i);
        logic [63:0] v;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] f;
        v = ATAN_PICO[i % 32];
        q = v / PICO_DEG;
        r = v % PICO_DEG;
        f = ((r << FRAC_BITS) + PICO_DEG / 2) / PICO_DEG;
        return ACC_W'((q << FRAC_BITS) + f);
    endfunction

    // accumulator to Q9.16, wrapped into [0, 360)
    function automatic logic [DEG_W-1:0] to_deg(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0]  rnd;
        logic signed [WRAP_W-1:0] v;
        rnd = '0;
        if (FRAC_BITS > 16)
        begin
            rnd = ACC_W'(1) <<< RND_SH;
            v = WRAP_W'((a + rnd) >>> DN_SH);
        end
        else if (FRAC_BITS == 16)
        begin
            v = WRAP_W'(a);
        end
        else
        begin
            v = WRAP_W'(a) <<< UP_SH;
        end
        if (v < 0)
        begin
            v = v + signed'(WRAP_W'(DEG_360));
        end
        else if (v >= signed'(WRAP_W'(DEG_360)))
        begin
            v = v - signed'(WRAP_W'(DEG_360));
        end
        return v[DEG_W-1:0];
    endfunction

endpackage

### design/vtpy_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor result.
// Depends on vtpy_pkg (side_t, widths).
module vtpy_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  vtpy_pkg::side_t               in_side,
    input  logic [vtpy_pkg::SQ_W-1:0]     in_n,
    output vtpy_pkg::side_t               out_side,
    output logic [vtpy_pkg::ROOT_W-1:0]   out_root
);

    localparam int N = vtpy_pkg::ISQ_STEPS;
    localparam int W = vtpy_pkg::SQ_W;

    vtpy_pkg::side_t side_reg [N];
    logic [W-1:0]    n_reg    [N];
    logic [W-1:0]    r_reg    [N];
    logic [W-1:0]    n_next   [N];
    logic [W-1:0]    r_next   [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
        logic [W-1:0] n_in;
        logic [W-1:0] r_in;
        logic [W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign n_in = in_n;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_comb
        begin
            if (n_in >= trial)
            begin
                n_next[k] = n_in - trial;
                r_next[k] = (r_in >> 1) + BIT;
            end
            else
            begin
                n_next[k] = n_in;
                r_next[k] = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else if (en)
            begin
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign out_side = side_reg[N-1];
    assign out_root = r_reg[N-1][vtpy_pkg::ROOT_W-1:0];

endmodule

### design/vtpy_cordic.sv
// Two-lane unrolled CORDIC in vectoring mode, one iteration per stage.
// Depends on vtpy_pkg (lane_t, tag_t, stage_angle).
module vtpy_cordic
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  vtpy_pkg::tag_t                        in_tag,
    input  logic signed [vtpy_pkg::CW-1:0]        in_px,
    input  logic signed [vtpy_pkg::CW-1:0]        in_py,
    input  logic signed [vtpy_pkg::CW-1:0]        in_wx,
    input  logic signed [vtpy_pkg::CW-1:0]        in_wy,
    output vtpy_pkg::tag_t                        out_tag,
    output logic signed [vtpy_pkg::ACC_W-1:0]     out_pitch_acc,
    output logic signed [vtpy_pkg::ACC_W-1:0]     out_yaw_acc
);

    localparam int N = vtpy_pkg::CORDIC_STAGES;

    vtpy_pkg::tag_t  tag_reg [N+1];
    vtpy_pkg::lane_t p_reg   [N+1];
    vtpy_pkg::lane_t w_reg   [N+1];
    vtpy_pkg::lane_t p_next  [N+1];
    vtpy_pkg::lane_t w_next  [N+1];

    // left half-plane: turn by 180 degrees first
    function automatic vtpy_pkg::lane_t prerot(input logic signed [vtpy_pkg::CW-1:0] x,
                                               input logic signed [vtpy_pkg::CW-1:0] y);
        vtpy_pkg::lane_t l;
        if (x < 0)
        begin
            l.x   = -x;
            l.y   = -y;
            l.acc = vtpy_pkg::ACC_W'(180) <<< vtpy_pkg::FRAC_BITS;
        end
        else
        begin
            l.x   = x;
            l.y   = y;
            l.acc = '0;
        end
        return l;
    endfunction

    // zero residual takes the negative branch
    function automatic vtpy_pkg::lane_t rotate(input vtpy_pkg::lane_t l, input int sh,
                                               input logic signed [vtpy_pkg::ACC_W-1:0] ang);
        vtpy_pkg::lane_t o;
        logic signed [vtpy_pkg::CW-1:0] dx;
        logic signed [vtpy_pkg::CW-1:0] dy;
        dx = l.y >>> sh;
        dy = l.x >>> sh;
        if (l.y > 0)
        begin
            o.x   = l.x + dx;
            o.y   = l.y - dy;
            o.acc = l.acc + ang;
        end
        else
        begin
            o.x   = l.x - dx;
            o.y   = l.y + dy;
            o.acc = l.acc - ang;
        end
        return o;
    endfunction

    always_comb
    begin
        p_next[0] = prerot(in_px, in_py);
        w_next[0] = prerot(in_wx, in_wy);
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [vtpy_pkg::ACC_W-1:0] ANG = vtpy_pkg::stage_angle(i);
        always_comb
        begin
            p_next[i+1] = rotate(p_reg[i], i, ANG);
            w_next[i+1] = rotate(w_reg[i], i, ANG);
        end
    end

    for (genvar s = 0; s <= N; s++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else if (en)
            begin
                tag_reg[s] <= (s == 0) ? in_tag : tag_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[s] <= p_next[s];
                w_reg[s] <= w_next[s];
            end
        end
    end

    assign out_tag       = tag_reg[N];
    assign out_pitch_acc = p_reg[N].acc;
    assign out_yaw_acc   = w_reg[N].acc;

endmodule

### design/vector_to_pitch_yaw.sv
// Top level: direction vector to pitch and yaw in degrees, stream in and out.
// Depends on vtpy_pkg, vtpy_isqrt and vtpy_cordic.
//
// Takes one signed Q16.16 vector (x, y, z) per request and returns pitch =
// atan2(-z, sqrt(x^2+y^2)) and yaw = atan2(y, x), unsigned Q9.16 degrees in
// [0, 360). When |x| and |y| are both at or below horiz_epsilon the answer is
// fixed (pitch 270 for z > 0, else 90; yaw 0) and m_tuser is set. The block
// is a fully pipelined single-enable chain: a new request is taken every
// cycle while the output is not stalled. Pipeline order: input
// register, abs, squares, sum, 32 square-root stages, CORDIC pre-rotation,
// one stage per CORDIC iteration, output rounding. The whole chain holds
// while the output request waits, so s_tready follows m_tready one-for-one
// once the output register is full. Write horiz_epsilon only while idle.
module vector_to_pitch_yaw
(
    input  logic        clk,
    input  logic        rst_n,
    // request in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [31:0] vec_x, [63:32] vec_y, [95:64] vec_z
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [24:0] pitch_deg, [49:25] yaw_deg, rest zero
    output logic        m_tuser,   // degenerate
    // horiz_epsilon
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int IN_W  = vtpy_pkg::IN_W;
    localparam int CW    = vtpy_pkg::CW;
    localparam int DEG_W = vtpy_pkg::DEG_W;

    logic en;

    logic [vtpy_pkg::EPS_W-1:0] eps_reg;

    // stage A: input register
    logic                   a_valid_reg;
    logic signed [IN_W-1:0] a_x_reg;
    logic signed [IN_W-1:0] a_y_reg;
    logic signed [IN_W-1:0] a_z_reg;

    // stage B: magnitudes and the near-vertical test
    vtpy_pkg::side_t b_side_reg;
    vtpy_pkg::side_t b_side_next;
    logic [IN_W-1:0] b_ax_reg;
    logic [IN_W-1:0] b_ay_reg;
    logic [IN_W-1:0] b_ax_next;
    logic [IN_W-1:0] b_ay_next;

    // stage C: squares
    vtpy_pkg::side_t             c_side_reg;
    logic [vtpy_pkg::SQ_W-1:0]   c_sqx_reg;
    logic [vtpy_pkg::SQ_W-1:0]   c_sqy_reg;

    // stage D: sum of squares
    vtpy_pkg::side_t             d_side_reg;
    logic [vtpy_pkg::SQ_W-1:0]   d_n_reg;

    // square root
    vtpy_pkg::side_t             q_side;
    logic [vtpy_pkg::ROOT_W-1:0] q_root;

    // CORDIC
    vtpy_pkg::tag_t                       k_tag_in;
    logic signed [CW-1:0]                 k_px;
    logic signed [CW-1:0]                 k_py;
    logic signed [CW-1:0]                 k_wx;
    logic signed [CW-1:0]                 k_wy;
    vtpy_pkg::tag_t                       k_tag;
    logic signed [vtpy_pkg::ACC_W-1:0]    k_pitch_acc;
    logic signed [vtpy_pkg::ACC_W-1:0]    k_yaw_acc;

    // output register
    logic             out_valid_reg;
    logic [DEG_W-1:0] out_pitch_reg;
    logic [DEG_W-1:0] out_yaw_reg;
    logic             out_degen_reg;
    logic [DEG_W-1:0] out_pitch_next;
    logic [DEG_W-1:0] out_yaw_next;

    // whole pipe moves unless a finished result is stuck at the output
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= vtpy_pkg::EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    // ---- stage A
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg <= s_tdata[31:0];
            a_y_reg <= s_tdata[63:32];
            a_z_reg <= s_tdata[95:64];
        end
    end

    // ---- stage B; -(-2^31) wraps to 2^31 as an unsigned magnitude
    always_comb
    begin
        b_ax_next = (a_x_reg < 0) ? IN_W'(-a_x_reg) : IN_W'(a_x_reg);
        b_ay_next = (a_y_reg < 0) ? IN_W'(-a_y_reg) : IN_W'(a_y_reg);
        b_side_next.valid = a_valid_reg;
        b_side_next.degen = (b_ax_next <= IN_W'(eps_reg)) && (b_ay_next <= IN_W'(eps_reg));
        b_side_next.zpos  = (a_z_reg > 0);
        b_side_next.x     = a_x_reg;
        b_side_next.y     = a_y_reg;
        b_side_next.z     = a_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_side_reg <= '0;
            c_side_reg <= '0;
            d_side_reg <= '0;
        end
        else if (en)
        begin
            b_side_reg <= b_side_next;
            c_side_reg <= b_side_reg;
            d_side_reg <= c_side_reg;
        end
    end

    // ---- stages B, C, D payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ax_reg  <= b_ax_next;
            b_ay_reg  <= b_ay_next;
            c_sqx_reg <= vtpy_pkg::SQ_W'(b_ax_reg) * vtpy_pkg::SQ_W'(b_ax_reg);
            c_sqy_reg <= vtpy_pkg::SQ_W'(b_ay_reg) * vtpy_pkg::SQ_W'(b_ay_reg);
            d_n_reg   <= c_sqx_reg + c_sqy_reg;
        end
    end

    vtpy_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_side  (d_side_reg),
        .in_n     (d_n_reg),
        .out_side (q_side),
        .out_root (q_root)
    );

    // operands carry 20 guard bits below the Q16.16 point
    always_comb
    begin
        k_tag_in.valid = q_side.valid;
        k_tag_in.degen = q_side.degen;
        k_tag_in.zpos  = q_side.zpos;
        k_px = CW'(signed'({1'b0, q_root})) <<< vtpy_pkg::GUARD_SH;
        k_py = (-CW'(q_side.z)) <<< vtpy_pkg::GUARD_SH;
        k_wx = CW'(q_side.x) <<< vtpy_pkg::GUARD_SH;
        k_wy = CW'(q_side.y) <<< vtpy_pkg::GUARD_SH;
    end

    vtpy_cordic u_cordic
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_tag        (k_tag_in),
        .in_px         (k_px),
        .in_py         (k_py),
        .in_wx         (k_wx),
        .in_wy         (k_wy),
        .out_tag       (k_tag),
        .out_pitch_acc (k_pitch_acc),
        .out_yaw_acc   (k_yaw_acc)
    );

    // ---- output stage: round, wrap, substitute the fixed answer
    always_comb
    begin
        if (k_tag.degen)
        begin
            out_pitch_next = k_tag.zpos ? vtpy_pkg::DEG_270 : vtpy_pkg::DEG_90;
            out_yaw_next   = '0;
        end
        else
        begin
            out_pitch_next = vtpy_pkg::to_deg(k_pitch_acc);
            out_yaw_next   = vtpy_pkg::to_deg(k_yaw_acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= k_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pitch_reg <= out_pitch_next;
            out_yaw_reg   <= out_yaw_next;
            out_degen_reg <= k_tag.degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_yaw_reg, out_pitch_reg};
    assign m_tuser  = out_degen_reg;

    // ---- checks
    a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[24:0] < vtpy_pkg::DEG_360) && (m_tdata[49:25] < vtpy_pkg::DEG_360))
        else $error("angle out of [0, 360)");

    a_degen_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[49:25] == '0) &&
            ((m_tdata[24:0] == vtpy_pkg::DEG_90) || (m_tdata[24:0] == vtpy_pkg::DEG_270)))
        else $error("degenerate result not the fixed answer");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !s_tready ##1
            (out_valid_reg && $stable(out_pitch_reg) && $stable(out_yaw_reg)))
        else $error("output moved or input taken during stall");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[55:50] == '0))
        else $error("tdata padding not zero");

endmodule

### tb/tb.sv
// Testbench for vector_to_pitch_yaw: directed and random vectors, results checked
// against a behavioral CORDIC/isqrt predictor. Depends on vtpy_pkg and the RTL.
module tb;

    localparam int LATENCY   = vtpy_pkg::CORDIC_STAGES + 38;
    localparam int MAX_CYCLE = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // [31:0] vec_x, [63:32] vec_y, [95:64] vec_z
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [24:0] pitch_deg, [49:25] yaw_deg, rest zero
    logic        m_tuser;   // degenerate
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    typedef struct packed {
        logic [vtpy_pkg::DEG_W-1:0] pitch;
        logic [vtpy_pkg::DEG_W-1:0] yaw;
        logic                       degen;
    } angles_t;

    angles_t                    pending_angles[$];
    logic [vtpy_pkg::EPS_W-1:0] eps_model;
    int                         mismatches;
    int                         cycle_count;
    bit                         idle_on;   // random idling enabled on both sides

    vector_to_pitch_yaw dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------- predictor ----------------

    function automatic longint arith_shr(longint v, int s);
        return v >>> s;
    endfunction

    // atan(2^-i) in accumulator units, half up
    function automatic longint atan_step(int i);
        longint unsigned v;
        longint unsigned q;
        longint unsigned r;
        longint unsigned f;
        v = vtpy_pkg::ATAN_PICO[i % 32];
        q = v / vtpy_pkg::PICO_DEG;
        r = v % vtpy_pkg::PICO_DEG;
        f = ((r << vtpy_pkg::FRAC_BITS) + vtpy_pkg::PICO_DEG / 2) / vtpy_pkg::PICO_DEG;
        return longint'((q << vtpy_pkg::FRAC_BITS) + f);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = longint'(180) << vtpy_pkg::FRAC_BITS;
        end
        for (int i = 0; i < vtpy_pkg::CORDIC_STAGES; i++)
        begin
            dx = arith_shr(y, i);
            dy = arith_shr(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                acc += atan_step(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                acc -= atan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic logic [vtpy_pkg::DEG_W-1:0] wrap_degrees(longint a);
        longint v;
        longint full;
        full = longint'(360) << 16;
        if (vtpy_pkg::FRAC_BITS > 16)
            v = arith_shr(a + (longint'(1) << (vtpy_pkg::FRAC_BITS - 17)),
                          vtpy_pkg::FRAC_BITS - 16);
        else
            v = a * (longint'(1) << (16 - vtpy_pkg::FRAC_BITS));
        while (v < 0)
            v += full;
        while (v >= full)
            v -= full;
        return v[vtpy_pkg::DEG_W-1:0];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic angles_t predict_angles(logic [95:0] d);
        angles_t         r;
        longint          x;
        longint          y;
        longint          z;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned h;
        x = longint'($signed(d[31:0]));
        y = longint'($signed(d[63:32]));
        z = longint'($signed(d[95:64]));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (ax <= eps_model && ay <= eps_model)
        begin
            r.pitch = (z > 0) ? vtpy_pkg::DEG_270 : vtpy_pkg::DEG_90;
            r.yaw   = '0;
            r.degen = 1'b1;
            return r;
        end
        h = root_floor(ax * ax + ay * ay);
        r.pitch = wrap_degrees(vector_angle(-z * 1048576, longint'(h) * 1048576));
        r.yaw   = wrap_degrees(vector_angle(y * 1048576, x * 1048576));
        r.degen = 1'b0;
        return r;
    endfunction

    // ---------------- drivers ----------------

    // called and returns at a falling edge; tvalid stays high for a following request
    task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (idle_on && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_angles.push_back(predict_angles({z, y, x}));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_epsilon(logic [15:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        eps_model = v;
    endtask

    function automatic logic [31:0] random_component();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(40)) - 20);
            2: return 32'($signed($urandom_range(200000)) - 100000);
            3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            default: return 32'($signed($urandom_range(2000000000)) - 1000000000);
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_extremes();
        logic [31:0] e[6];
        e = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1, 32'h0001_0000};
        for (int i = 0; i < 6; i++)
            send_vector(e[i], e[(i + 1) % 6], e[(i + 3) % 6]);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    endtask

    // near-zero horizontal part, both z signs and z == 0, at the epsilon edge
    task automatic test_degenerate();
        send_vector(32'd0, 32'd0, 32'd5);
        send_vector(32'd0, 32'd0, 32'd0);
        send_vector(32'd0, 32'd0, -32'sd5);
        send_vector(32'd7, -32'sd7, 32'd1);
        send_vector(-32'sd7, 32'd8, 32'd1);
        send_vector(32'd8, 32'd0, -32'sd1);
    endtask

    // axes and quadrants, negative x takes the pre-rotation path
    task automatic test_quadrants();
        send_vector(32'h0001_0000, 32'd0, 32'd0);
        send_vector(-32'sh0001_0000, 32'd0, 32'd0);
        send_vector(32'd0, 32'h0001_0000, 32'h0001_0000);
        send_vector(32'd0, -32'sh0001_0000, -32'sh0001_0000);
        send_vector(-32'sh0003_0000, 32'h0004_0000, 32'd0);
        send_vector(-32'sh0003_0000, -32'sh0004_0000, 32'h0005_0000);
    endtask

    task automatic test_epsilon_settings();
        logic [15:0] eps_set[4];
        eps_set = '{16'd0, 16'hffff, 16'd300, 16'd1};
        for (int k = 0; k < 4; k++)
        begin
            write_epsilon(eps_set[k]);
            send_vector(32'(eps_set[k]), 32'(eps_set[k]), 32'd9);
            send_vector(32'(eps_set[k]) + 1, 32'd0, -32'sd9);
            for (int i = 0; i < 40; i++)
                send_vector(random_component(), random_component(), random_component());
        end
    endtask

    task automatic test_random_stream();
        write_epsilon(16'd7);
        for (int i = 0; i < 900; i++)
        begin
            // a long unbroken stretch in the middle
            idle_on = !(i >= 300 && i < 500);
            send_vector(random_component(), random_component(), random_component());
        end
        idle_on = 1'b1;
    endtask

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin
        angles_t want;
        angles_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[24:0], m_tdata[49:25], m_tuser};
            if (pending_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result pitch=%0d yaw=%0d degen=%0b",
                             got.pitch, got.yaw, got.degen);
            end
            else
            begin
                want = pending_angles.pop_front();
                if (got !== want || m_tdata[55:50] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp pitch=%0d yaw=%0d degen=%0b, got %0d %0d %0b",
                                 want.pitch, want.yaw, want.degen,
                                 got.pitch, got.yaw, got.degen);
                end
            end
        end
    end

    // receiver stall, also random
    always @(negedge clk)
    begin
        m_tready <= !(idle_on && $urandom_range(99) < 24);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("FAIL vector_to_pitch_yaw");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        eps_model   = vtpy_pkg::EPS_RESET;
        mismatches  = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_extremes();
        test_degenerate();
        test_quadrants();
        test_epsilon_settings();
        test_random_stream();
        wait_drained();

        if (mismatches == 0 && pending_angles.size() == 0)
            $display("PASS vector_to_pitch_yaw");
        else
            $display("FAIL vector_to_pitch_yaw");
        $finish;
    end
endmodule
